// ----- rtl/tbprq_pkg.sv -----
package tbprq_pkg;

  localparam int CMD_W    = 2;
  localparam int TASK_W   = 6;
  localparam int PRIO_W   = 5;
  localparam int STATUS_W = 2;
  localparam int PLACE_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  localparam logic [PLACE_W-1:0] PLACE_NONE = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_B0   = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_B1   = 2'd2;

endpackage

// ----- rtl/two_bank_priority_ready_queue_unit.sv -----
// Channel   Direction  Signals                                   Transfer
// command   in         start, command_i, task_id_i,              start && !busy
//                      task_priority_i
// result    out        result_valid_o, status_o, popped_task_o   result_valid_o, one cycle
//
// A command that is rejected at once completes from the idle state; push, delete and pop
// run longer, as set by the chain of dependent link-memory reads, each with a registered
// read port and one read and one write per memory per cycle.
// After reset a clearing pass over all NUM_TASKS entries resets the task placement
// memory; busy stays high during it. The registered result appears in the cycle after
// the command's last state, and busy is low in that cycle. The receiver cannot stall results.
module two_bank_priority_ready_queue_unit
  import tbprq_pkg::*;
#(
  parameter int NUM_TASKS  = 64,
  parameter int NUM_LEVELS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [TASK_W-1:0]   task_id_i,
  input  logic [PRIO_W-1:0]   task_priority_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [TASK_W-1:0]   popped_task_o
);

  localparam int TW        = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LW        = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SW        = LW + 1;
  localparam int NUM_SLOTS = 2 * (1 << LW);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_D1, S_O1, S_U1, S_A1, S_A2, S_A3
  } state_e;

  state_e state_q, state_d;
  logic                               act_q, act_d;
  logic [1:0][NUM_LEVELS-1:0]         bm_q, bm_d;
  logic [TW-1:0]                      tid_q, tid_d;
  logic [LW-1:0]                      lvl_q, lvl_d;
  logic                               bk_q, bk_d;
  logic [TW-1:0]                      hd_q, hd_d;
  logic                               pop_q, pop_d;
  logic                               chk_q, chk_d;
  logic [TW-1:0]                      clr_q, clr_d;
  logic                               valid_q, valid_d;
  logic [STATUS_W-1:0]                status_q, status_d;
  logic [TASK_W-1:0]                  popped_q, popped_d;

  logic [PLACE_W-1:0] place_mem [NUM_TASKS];
  logic [LW-1:0]      level_mem [NUM_TASKS];
  logic [TW-1:0]      next_mem  [NUM_TASKS];
  logic [TW-1:0]      prev_mem  [NUM_TASKS];
  logic [TW-1:0]      head_mem  [NUM_SLOTS];

  logic               p_we, l_we, n_we, v_we, h_we;
  logic [TW-1:0]      p_wa, l_wa, n_wa, v_wa;
  logic [SW-1:0]      h_wa;
  logic [PLACE_W-1:0] p_wd;
  logic [LW-1:0]      l_wd;
  logic [TW-1:0]      n_wd, v_wd, h_wd;
  logic [TW-1:0]      p_ra, l_ra, n_ra, v_ra;
  logic [SW-1:0]      h_ra;
  logic [PLACE_W-1:0] place_rd_q;
  logic [LW-1:0]      level_rd_q;
  logic [TW-1:0]      next_rd_q, prev_rd_q, head_rd_q;

  logic [NUM_LEVELS-1:0] bm_act;
  logic [LW-1:0]         top_lvl;
  logic [TW-1:0]         tid_in;
  logic [LW-1:0]         lvl_in;
  logic                  tid_ok, lvl_ok;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign popped_task_o  = popped_q;

  assign tid_in = TW'(task_id_i);
  assign lvl_in = LW'(task_priority_i);
  assign tid_ok = (32'(task_id_i) < NUM_TASKS);
  assign lvl_ok = (32'(task_priority_i) < NUM_LEVELS);
  assign bm_act = bm_q[act_q];

  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (bm_act[i]) begin
        top_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    bm_d     = bm_q;
    tid_d    = tid_q;
    lvl_d    = lvl_q;
    bk_d     = bk_q;
    hd_d     = hd_q;
    pop_d    = pop_q;
    chk_d    = chk_q;
    clr_d    = clr_q;
    valid_d  = 1'b0;
    status_d = status_q;
    popped_d = popped_q;

    p_we = 1'b0; p_wa = tid_q; p_wd = PLACE_NONE;
    l_we = 1'b0; l_wa = tid_q; l_wd = lvl_q;
    n_we = 1'b0; n_wa = tid_q; n_wd = tid_q;
    v_we = 1'b0; v_wa = tid_q; v_wd = tid_q;
    h_we = 1'b0; h_wa = {bk_q, lvl_q}; h_wd = tid_q;
    p_ra = tid_q;
    l_ra = tid_q;
    n_ra = tid_q;
    v_ra = tid_q;
    h_ra = {bk_q, lvl_q};

    case (state_q)
      S_CLR: begin
        p_we  = 1'b1;
        p_wa  = clr_q;
        p_wd  = PLACE_NONE;
        clr_d = clr_q + 1'b1;
        if (clr_q == TW'(NUM_TASKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          tid_d    = tid_in;
          lvl_d    = lvl_in;
          pop_d    = 1'b0;
          popped_d = '0;
          case (command_i)
            CMD_PUSH: begin
              if (tid_ok && lvl_ok) begin
                bk_d    = act_q;
                chk_d   = 1'b1;
                p_ra    = tid_in;
                h_ra    = {act_q, lvl_in};
                state_d = S_A1;
              end else begin
                valid_d  = 1'b1;
                status_d = ST_REJECT;
              end
            end
            CMD_POP: begin
              if (bm_act == '0) begin
                valid_d  = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                lvl_d   = top_lvl;
                bk_d    = act_q;
                pop_d   = 1'b1;
                h_ra    = {act_q, top_lvl};
                state_d = S_O1;
              end
            end
            CMD_DELETE: begin
              if (tid_ok) begin
                p_ra    = tid_in;
                l_ra    = tid_in;
                state_d = S_D1;
              end else begin
                valid_d  = 1'b1;
                status_d = ST_REJECT;
              end
            end
            default: begin
              valid_d  = 1'b1;
              status_d = ST_REJECT;
            end
          endcase
        end
      end
      S_D1: begin
        if (place_rd_q == PLACE_B0 || place_rd_q == PLACE_B1) begin
          bk_d    = (place_rd_q == PLACE_B1);
          lvl_d   = level_rd_q;
          h_ra    = {(place_rd_q == PLACE_B1), level_rd_q};
          state_d = S_U1;
        end else begin
          valid_d  = 1'b1;
          status_d = ST_REJECT;
          state_d  = S_IDLE;
        end
      end
      S_O1: begin
        tid_d   = head_rd_q;
        n_ra    = head_rd_q;
        v_ra    = head_rd_q;
        state_d = S_U1;
      end
      S_U1: begin
        if (next_rd_q == tid_q) begin
          h_we = 1'b1;
          h_wd = '0;
          bm_d[bk_q][lvl_q] = 1'b0;
        end else begin
          n_we = 1'b1;
          n_wa = prev_rd_q;
          n_wd = next_rd_q;
          v_we = 1'b1;
          v_wa = next_rd_q;
          v_wd = prev_rd_q;
          if (head_rd_q == tid_q) begin
            h_we = 1'b1;
            h_wd = next_rd_q;
          end
        end
        p_we = 1'b1;
        p_wd = PLACE_NONE;
        if (pop_q) begin
          bk_d    = ~bk_q;
          chk_d   = 1'b0;
          h_ra    = {~bk_q, lvl_q};
          state_d = S_A1;
        end else begin
          valid_d  = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end
      S_A1: begin
        if (chk_q && place_rd_q != PLACE_NONE) begin
          valid_d  = 1'b1;
          status_d = ST_REJECT;
          state_d  = S_IDLE;
        end else if (!bm_q[bk_q][lvl_q]) begin
          n_we = 1'b1;
          v_we = 1'b1;
          h_we = 1'b1;
          l_we = 1'b1;
          p_we = 1'b1;
          p_wd = bk_q ? PLACE_B1 : PLACE_B0;
          bm_d[bk_q][lvl_q] = 1'b1;
          valid_d  = 1'b1;
          status_d = ST_OK;
          popped_d = pop_q ? TASK_W'(tid_q) : '0;
          if (pop_q && bm_q[~bk_q] == '0) begin
            act_d = bk_q;
          end
          state_d = S_IDLE;
        end else begin
          hd_d    = head_rd_q;
          v_ra    = head_rd_q;
          state_d = S_A2;
        end
      end
      S_A2: begin
        n_we = 1'b1;
        n_wa = prev_rd_q;
        n_wd = tid_q;
        v_we = 1'b1;
        v_wd = prev_rd_q;
        l_we = 1'b1;
        p_we = 1'b1;
        p_wd = bk_q ? PLACE_B1 : PLACE_B0;
        state_d = S_A3;
      end
      S_A3: begin
        n_we = 1'b1;
        n_wd = hd_q;
        v_we = 1'b1;
        v_wa = hd_q;
        v_wd = tid_q;
        valid_d  = 1'b1;
        status_d = ST_OK;
        popped_d = pop_q ? TASK_W'(tid_q) : '0;
        if (pop_q && bm_q[~bk_q] == '0) begin
          act_d = bk_q;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      act_q    <= 1'b0;
      bm_q     <= '0;
      tid_q    <= '0;
      lvl_q    <= '0;
      bk_q     <= 1'b0;
      hd_q     <= '0;
      pop_q    <= 1'b0;
      chk_q    <= 1'b0;
      clr_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
      popped_q <= '0;
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      bm_q     <= bm_d;
      tid_q    <= tid_d;
      lvl_q    <= lvl_d;
      bk_q     <= bk_d;
      hd_q     <= hd_d;
      pop_q    <= pop_d;
      chk_q    <= chk_d;
      clr_q    <= clr_d;
      valid_q  <= valid_d;
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      place_mem[p_wa] <= p_wd;
    end
    place_rd_q <= place_mem[p_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      level_mem[l_wa] <= l_wd;
    end
    level_rd_q <= level_mem[l_ra];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
    next_rd_q <= next_mem[n_ra];
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      prev_mem[v_wa] <= v_wd;
    end
    prev_rd_q <= prev_mem[v_ra];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      head_mem[h_wa] <= h_wd;
    end
    head_rd_q <= head_mem[h_ra];
  end

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_POP && bm_act == '0)
      |=> (result_valid_o && status_o == ST_EMPTY))
    else $error("Pop on an empty active bank did not report empty.");

  a_popped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |-> (popped_task_o == '0))
    else $error("Failed command returned a nonzero task.");

  a_swap_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q != $past(act_q)) |-> (result_valid_o && status_o == ST_OK))
    else $error("Banks swapped outside a successful pop.");

  a_unlink_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_U1) |-> bm_q[bk_q][lvl_q])
    else $error("Unlink from a level that is marked empty.");

endmodule

// ----- tb/tb_ready_queue_pkg.sv -----
package tb_ready_queue_pkg;
  import tbprq_pkg::*;

  localparam int NTASK = 64;
  localparam int NLVL  = 32;
  localparam int MAX_PRINTED = 40;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   popped;
  } queue_reply_t;

  class ready_queue_scoreboard;
    bit                active;
    bit [NLVL-1:0]     level_map [2];
    bit [TASK_W-1:0]   ring_head [2][NLVL];
    bit [TASK_W-1:0]   succ [NTASK];
    bit [TASK_W-1:0]   pred [NTASK];
    bit [PRIO_W-1:0]   level_of [NTASK];
    bit [PLACE_W-1:0]  place [NTASK];
    queue_reply_t      replies_due [$];
    int                errors;

    function new();
      active = 1'b0;
      level_map[0] = '0;
      level_map[1] = '0;
      foreach (place[i]) place[i] = PLACE_NONE;
      errors = 0;
    endfunction

    function void append(bit bank, int lv, int tid);
      int hd;
      int tl;
      if (!level_map[bank][lv]) begin
        succ[tid] = TASK_W'(tid);
        pred[tid] = TASK_W'(tid);
        ring_head[bank][lv] = TASK_W'(tid);
        level_map[bank][lv] = 1'b1;
      end else begin
        hd = ring_head[bank][lv];
        tl = pred[hd];
        succ[tl] = TASK_W'(tid);
        pred[tid] = TASK_W'(tl);
        succ[tid] = TASK_W'(hd);
        pred[hd] = TASK_W'(tid);
      end
      level_of[tid] = PRIO_W'(lv);
      place[tid] = bank ? PLACE_B1 : PLACE_B0;
    endfunction

    function void unlink(bit bank, int lv, int tid);
      int nx;
      int pv;
      nx = succ[tid];
      pv = pred[tid];
      if (nx == tid) begin
        ring_head[bank][lv] = '0;
        level_map[bank][lv] = 1'b0;
      end else begin
        succ[pv] = TASK_W'(nx);
        pred[nx] = TASK_W'(pv);
        if (ring_head[bank][lv] == tid) ring_head[bank][lv] = TASK_W'(nx);
      end
      place[tid] = PLACE_NONE;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid,
                               logic [PRIO_W-1:0] prio);
      queue_reply_t r;
      int top;
      bit bank;
      r.status = ST_REJECT;
      r.popped = '0;
      case (cmd)
        CMD_PUSH: begin
          if (place[tid] == PLACE_NONE) begin
            append(active, prio, tid);
            r.status = ST_OK;
          end
        end
        CMD_POP: begin
          top = -1;
          for (int l = NLVL - 1; l >= 0 && top < 0; l--) begin
            if (level_map[active][l]) top = l;
          end
          if (top < 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped = ring_head[active][top];
            unlink(active, top, r.popped);
            append(!active, top, r.popped);
            if (level_map[active] == '0) active = !active;
            r.status = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (place[tid] != PLACE_NONE) begin
            bank = (place[tid] == PLACE_B1);
            unlink(bank, level_of[tid], tid);
            r.status = ST_OK;
          end
        end
        default: begin
        end
      endcase
      replies_due.push_back(r);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [TASK_W-1:0] popped);
      queue_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("result with no command outstanding, status %0d task %0d",
                         status, popped));
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, predicted %0d", status, want.status));
        if (popped !== want.popped)
          report($sformatf("popped task %0d, predicted %0d", popped, want.popped));
      end
    endtask
  endclass

endpackage

// ----- tb/tb_top.sv -----
module tb_top;
  import tbprq_pkg::*;
  import tb_ready_queue_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command_i = CMD_PUSH;
  logic [TASK_W-1:0]   task_id_i = '0;
  logic [PRIO_W-1:0]   task_priority_i = '0;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [TASK_W-1:0]   popped_task_o;

  ready_queue_scoreboard sched_model;
  int cycles = 0;
  int burst_left = 0;

  two_bank_priority_ready_queue_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .popped_task_o  (popped_task_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else if (rst_ni) begin
      if (result_valid_o) sched_model.check_result(status_o, popped_task_o);
      if (start && !busy) sched_model.note_command(command_i, task_id_i, task_priority_i);
    end
  end

  task automatic issue(logic [CMD_W-1:0] cmd, logic [TASK_W-1:0] tid,
                       logic [PRIO_W-1:0] prio);
    int gap;
    start <= 1'b1;
    command_i <= cmd;
    task_id_i <= tid;
    task_priority_i <= prio;
    do @(posedge clk_i); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Pushes mostly pick a free task and deletes mostly a queued one, so that
  // the rings grow deep and the banks swap often.
  task automatic random_item(int push_w, int pop_w);
    int pick;
    logic [TASK_W-1:0] tid;
    logic [PRIO_W-1:0] prio;
    bit want_queued;
    pick = $urandom_range(0, 99);
    tid = TASK_W'($urandom());
    prio = PRIO_W'($urandom());
    if (pick < 2) begin
      issue(CMD_UNUSED, tid, prio);
    end else if (pick < 2 + pop_w) begin
      issue(CMD_POP, tid, prio);
    end else begin
      want_queued = (pick >= 2 + pop_w + push_w);
      if ($urandom_range(0, 9) != 0) begin
        for (int k = 0; k < 16 && ((sched_model.place[tid] != PLACE_NONE) != want_queued);
             k++) begin
          tid = TASK_W'($urandom());
        end
      end
      if (!want_queued && $urandom_range(0, 1) == 1)
        prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(29, 31))
                                    : PRIO_W'($urandom_range(0, 2));
      issue(want_queued ? CMD_DELETE : CMD_PUSH, tid, prio);
    end
  endtask

  initial begin
    int push_w;
    int pop_w;
    sched_model = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_PUSH,   6'd0,  5'd0);
    issue(CMD_PUSH,   6'd63, 5'd31);
    issue(CMD_PUSH,   6'd0,  5'd5);
    issue(CMD_PUSH,   6'd5,  5'd31);
    issue(CMD_PUSH,   6'd6,  5'd31);
    issue(CMD_PUSH,   6'd10, 5'd17);
    issue(CMD_DELETE, 6'd42, 5'd0);
    issue(CMD_UNUSED, 6'd63, 5'd31);
    issue(CMD_DELETE, 6'd5,  5'd31);
    issue(CMD_POP,    6'd63, 5'd31);
    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_PUSH,   6'd7,  5'd31);
    issue(CMD_DELETE, 6'd63, 5'd0);
    issue(CMD_DELETE, 6'd10, 5'd0);
    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_DELETE, 6'd0,  5'd0);
    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_PUSH,   6'd1,  5'd3);
    issue(CMD_POP,    6'd0,  5'd0);
    issue(CMD_POP,    6'd0,  5'd0);

    for (int p = 0; p < PHASES; p++) begin
      push_w = $urandom_range(20, 55);
      pop_w = $urandom_range(15, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item(push_w, pop_w);
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (sched_model.replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sched_model.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tbprq_pkg.sv
rtl/two_bank_priority_ready_queue_unit.sv
tb/tb_ready_queue_pkg.sv
tb/tb_top.sv
